// ===== rtl/traffic_phase_split_adapter_defines.svh =====
// Assertion macros for the traffic phase split adapter.
// Depends on a clock named clk and a reset named rst in the using scope.
`ifndef TRAFFIC_PHASE_SPLIT_ADAPTER_DEFINES_SVH
`define TRAFFIC_PHASE_SPLIT_ADAPTER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define TPSA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tpsa assertion failed");

// Next-cycle implication, checked outside reset
`define TPSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tpsa assertion failed");

`endif

// ===== rtl/tpsa_pkg.sv =====
// Shared constants, codes and types of the traffic phase split adapter.
// No dependencies.
package tpsa_pkg;

  localparam int MAX_PHASES    = 8;
  localparam int NUM_LANES     = 8;
  localparam int HISTORY_DEPTH = 16;

  localparam int PH_W         = $clog2(MAX_PHASES);
  localparam int LANE_W       = $clog2(NUM_LANES);
  localparam int SLOT_W       = $clog2(HISTORY_DEPTH);
  localparam int HIST_ENTRIES = HISTORY_DEPTH * NUM_LANES;
  localparam int HIST_AW      = $clog2(HIST_ENTRIES);
  localparam int CNT_W        = $clog2(MAX_PHASES + NUM_LANES);
  localparam int QDEPTH       = 2;
  localparam int QAW          = $clog2(QDEPTH);

  localparam int CMD_W  = 2;
  localparam int PIDX_W = 3;
  localparam int TIME_W = 12;
  localparam int MASK_W = 8;
  localparam int LIDX_W = 3;
  localparam int CARS_W = 10;
  localparam int TICK_W = 15;
  localparam int STAT_W = 2;
  localparam int SUM_W  = 14;
  localparam int NP_W   = 4;
  localparam int WL_W   = 5;
  localparam int GAIN_W = 8;
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 12;
  localparam int QUO_W  = 12;
  localparam int DVS_W  = 4;

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_PHASE_COUNT   = 2'd0;
  localparam logic [CFG_AW-1:0] REG_WINDOW_LENGTH = 2'd1;
  localparam logic [CFG_AW-1:0] REG_MIN_TIME      = 2'd2;
  localparam logic [CFG_AW-1:0] REG_GAIN          = 2'd3;

  // Register reset values
  localparam logic [NP_W-1:0]   RST_PHASE_COUNT   = 4'd4;
  localparam logic [WL_W-1:0]   RST_WINDOW_LENGTH = 5'd8;
  localparam logic [TIME_W-1:0] RST_MIN_TIME      = 12'd5;
  localparam logic [GAIN_W-1:0] RST_GAIN          = 8'd26;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_ADAPTED  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_UNSERVED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_GREEN = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_ADAPT  = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [PIDX_W-1:0] phase_index;
    logic [TIME_W-1:0] phase_time;
    logic [MASK_W-1:0] lane_mask;
    logic [LIDX_W-1:0] lane_index;
    logic [CARS_W-1:0] stopped_cars;
    logic              snapshot_end;
  } item_t;

  typedef struct packed {
    logic [NP_W-1:0]   np;
    logic [WL_W-1:0]   wl;
    logic [TIME_W-1:0] min_time;
    logic [GAIN_W-1:0] gain;
    logic              win_clear;
  } cfg_t;

  typedef struct packed {
    logic div_busy;
    logic in_div;
    logic out_load;
    logic ring_zero;
  } bstat_t;

endpackage

// ===== rtl/tpsa_if.sv =====
// Request channel interfaces of the traffic phase split adapter.
// Depends on tpsa_pkg for field widths.
interface tpsa_in_if;
  logic                        valid;
  logic                        ready;
  logic [tpsa_pkg::CMD_W-1:0]  cmd;
  logic [tpsa_pkg::PIDX_W-1:0] phase_index;
  logic [tpsa_pkg::TIME_W-1:0] phase_time;
  logic [tpsa_pkg::MASK_W-1:0] lane_mask;
  logic [tpsa_pkg::LIDX_W-1:0] lane_index;
  logic [tpsa_pkg::CARS_W-1:0] stopped_cars;
  logic                        snapshot_end;
  modport source (output valid, cmd, phase_index, phase_time, lane_mask, lane_index,
                  stopped_cars, snapshot_end, input ready);
  modport sink (input valid, cmd, phase_index, phase_time, lane_mask, lane_index,
                stopped_cars, snapshot_end, output ready);
endinterface

interface tpsa_out_if;
  logic                        valid;
  logic                        ready;
  logic [tpsa_pkg::PIDX_W-1:0] out_phase;
  logic [tpsa_pkg::TICK_W-1:0] start_tick;
  logic [tpsa_pkg::TICK_W-1:0] end_tick;
  logic [tpsa_pkg::STAT_W-1:0] status;
  logic                        last_phase;
  modport source (output valid, out_phase, start_tick, end_tick, status, last_phase,
                  input ready);
  modport sink (input valid, out_phase, start_tick, end_tick, status, last_phase,
                output ready);
endinterface

interface tpsa_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tpsa_pkg::CFG_AW-1:0] addr;
  logic [tpsa_pkg::CFG_DW-1:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

// ===== rtl/tpsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tpsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tpsa_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on tpsa_pkg for operand widths.
module tpsa_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tpsa_pkg::QUO_W-1:0] dividend,
  input  logic [tpsa_pkg::DVS_W-1:0] divisor,
  output logic                       busy,
  output logic                       done,
  output logic [tpsa_pkg::QUO_W-1:0] quotient
);

  localparam int STEP_W = $clog2(tpsa_pkg::QUO_W + 1);

  logic [tpsa_pkg::DVS_W-1:0] rem;
  logic [tpsa_pkg::DVS_W-1:0] dvs;
  logic [STEP_W-1:0]          steps;
  logic [tpsa_pkg::DVS_W:0]   trial;

  assign trial = {rem, quotient[tpsa_pkg::QUO_W-1]};

  // Shift in one dividend bit, subtract where it fits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        quotient <= dividend;
        dvs      <= divisor;
        rem      <= '0;
        steps    <= STEP_W'(tpsa_pkg::QUO_W);
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem      <= tpsa_pkg::DVS_W'(trial - {1'b0, dvs});
          quotient <= {quotient[tpsa_pkg::QUO_W-2:0], 1'b1};
        end else begin
          rem      <= trial[tpsa_pkg::DVS_W-1:0];
          quotient <= {quotient[tpsa_pkg::QUO_W-2:0], 1'b0};
        end
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/tpsa_front.sv =====
// Front end: accepts requests, drops unknown commands, queues the rest.
// Depends on tpsa_pkg and tpsa_in_if.
module tpsa_front (
  input  logic            clk,
  input  logic            rst,
  tpsa_in_if.sink         items,
  output logic            q_valid,
  output tpsa_pkg::item_t q_item,
  input  logic            q_pop
);

  tpsa_pkg::item_t           slots [tpsa_pkg::QDEPTH];
  logic [tpsa_pkg::QAW-1:0]  wptr;
  logic [tpsa_pkg::QAW-1:0]  rptr;
  logic [tpsa_pkg::QAW:0]    count;
  logic                      known;
  logic                      push;
  logic                      pop;
  tpsa_pkg::item_t           decoded;

  // Classify the incoming request
  always_comb begin
    known = (items.cmd == tpsa_pkg::CMD_LOAD) || (items.cmd == tpsa_pkg::CMD_SAMPLE) ||
            (items.cmd == tpsa_pkg::CMD_ADAPT);
    decoded.cmd          = tpsa_pkg::cmd_t'(items.cmd);
    decoded.phase_index  = items.phase_index;
    decoded.phase_time   = items.phase_time;
    decoded.lane_mask    = items.lane_mask;
    decoded.lane_index   = items.lane_index;
    decoded.stopped_cars = items.stopped_cars;
    decoded.snapshot_end = items.snapshot_end;
  end

  assign items.ready = (count != (tpsa_pkg::QAW+1)'(tpsa_pkg::QDEPTH));
  assign push        = items.valid && items.ready && known;
  assign pop         = q_pop && q_valid;
  assign q_valid     = (count != '0);
  assign q_item      = slots[rptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= decoded;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/tpsa_back.sv =====
// Back end: carries out loads, samples and adapt runs, and drives results.
// Depends on tpsa_pkg, tpsa_out_if, tpsa_ram and tpsa_div.
module tpsa_back (
  input  logic             clk,
  input  logic             rst,
  input  tpsa_pkg::cfg_t   cfg,
  input  logic             q_valid,
  input  tpsa_pkg::item_t  q_item,
  output logic             q_pop,
  tpsa_out_if.source       results,
  output tpsa_pkg::bstat_t bstat
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SWR   = 10'b0000000010,
    S_LANE  = 10'b0000000100,
    S_PHASE = 10'b0000001000,
    S_MUL   = 10'b0000010000,
    S_DIVS  = 10'b0000100000,
    S_DIV   = 10'b0001000000,
    S_UPD   = 10'b0010000000,
    S_GROW  = 10'b0100000000,
    S_EMIT  = 10'b1000000000
  } state_t;

  localparam int TW  = tpsa_pkg::TIME_W;
  localparam int SW  = tpsa_pkg::SUM_W;
  localparam int KW  = tpsa_pkg::TICK_W;
  localparam int CW  = tpsa_pkg::CNT_W;
  localparam int PW  = tpsa_pkg::PH_W;
  localparam int PRW = tpsa_pkg::TIME_W + tpsa_pkg::GAIN_W;

  state_t state;

  logic [TW-1:0]                   dur   [tpsa_pkg::MAX_PHASES];
  logic [tpsa_pkg::MASK_W-1:0]     lanes [tpsa_pkg::MAX_PHASES];
  logic [SW-1:0]                   sums  [tpsa_pkg::NUM_LANES];
  logic [tpsa_pkg::HIST_ENTRIES-1:0] hv;
  logic [tpsa_pkg::SLOT_W-1:0]     ring_slot;

  tpsa_pkg::item_t                 cur;
  logic [tpsa_pkg::HIST_AW-1:0]    at;
  logic                            at_ok;
  logic [CW-1:0]                   cnt;
  logic [SW-1:0]                   best;
  logic [tpsa_pkg::LANE_W-1:0]     busiest;
  logic [tpsa_pkg::NP_W-1:0]       greens;
  logic [PW-1:0]                   grow;
  logic                            grow_found;
  logic [KW-1:0]                   total;
  logic [KW-1:0]                   others;
  logic [PRW-1:0]                  prod;
  logic [TW-1:0]                   minus;
  logic [tpsa_pkg::STAT_W-1:0]     status;
  logic [KW-1:0]                   start;

  logic                            res_valid;
  logic [PW-1:0]                   res_phase;
  logic [KW-1:0]                   res_start;
  logic [KW-1:0]                   res_end;
  logic [tpsa_pkg::STAT_W-1:0]     res_status;
  logic                            res_last;

  logic [tpsa_pkg::SLOT_W-1:0]     slot_eff;
  logic [tpsa_pkg::HIST_AW-1:0]    at_next;
  logic                            lane_ok;
  logic [CW-1:0]                   np_last;
  logic [PW-1:0]                   pidx;
  logic [PW-1:0]                   dur_idx;
  logic [TW-1:0]                   dur_rd;
  logic [tpsa_pkg::LANE_W-1:0]     sum_idx;
  logic [SW-1:0]                   sum_rd;
  logic                            green;
  logic signed [TW+1:0]            dsub;
  logic [TW-1:0]                   dnew;
  logic signed [KW+1:0]            gsum;
  logic [TW-1:0]                   gnew;
  logic [tpsa_pkg::CARS_W-1:0]     ram_rd;
  logic [tpsa_pkg::CARS_W-1:0]     old_cars;
  logic                            out_free;
  logic                            out_load;
  logic [tpsa_pkg::SLOT_W:0]       slot_inc;
  logic                            div_start;
  logic                            div_busy;
  logic                            div_done;
  logic [tpsa_pkg::QUO_W-1:0]      div_q;

  // Shared read selection and per-item arithmetic
  always_comb begin
    slot_eff = ({1'b0, ring_slot} >= cfg.wl) ? '0 : ring_slot;
    lane_ok  = int'(q_item.lane_index) < tpsa_pkg::NUM_LANES;
    at_next  = tpsa_pkg::HIST_AW'(int'(slot_eff) * tpsa_pkg::NUM_LANES
                                  + int'(q_item.lane_index));
    np_last  = CW'(cfg.np - tpsa_pkg::NP_W'(1));
    pidx     = cnt[PW-1:0];
    dur_idx  = (state == S_MUL) ? grow : pidx;
    dur_rd   = dur[dur_idx];
    sum_idx  = (state == S_LANE) ? cnt[tpsa_pkg::LANE_W-1:0]
                                 : cur.lane_index[tpsa_pkg::LANE_W-1:0];
    sum_rd   = sums[sum_idx];
    green    = (lanes[pidx] != '0);
    dsub     = $signed({2'b00, dur_rd}) - (green ? $signed({2'b00, minus}) : '0);
    if (green && (dsub < $signed({2'b00, cfg.min_time}))) begin
      dnew = cfg.min_time;
    end else begin
      dnew = dsub[TW-1:0];
    end
    gsum = $signed({2'b00, total}) - $signed({2'b00, others});
    if (gsum < $signed((KW+2)'(1))) begin
      gnew = TW'(1);
    end else if (gsum > $signed((KW+2)'((1 << TW) - 1))) begin
      gnew = TW'((1 << TW) - 1);
    end else begin
      gnew = gsum[TW-1:0];
    end
    old_cars = hv[at] ? ram_rd : '0;
    slot_inc = {1'b0, ring_slot} + 1'b1;
    out_free = !res_valid || results.ready;
    out_load = (state == S_EMIT) && out_free;
    q_pop    = (state == S_IDLE) && q_valid && !cfg.win_clear;
    div_start = (state == S_DIVS);
  end

  tpsa_ram #(
    .WIDTH (tpsa_pkg::CARS_W),
    .DEPTH (tpsa_pkg::HIST_ENTRIES)
  ) u_hist (
    .clk   (clk),
    .we    ((state == S_SWR) && at_ok),
    .waddr (at),
    .wdata (cur.stopped_cars),
    .raddr (at_next),
    .rdata (ram_rd)
  );

  tpsa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod[PRW-1:tpsa_pkg::GAIN_W]),
    .divisor  (greens),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      hv        <= '0;
      ring_slot <= '0;
      res_valid <= 1'b0;
      for (int i = 0; i < tpsa_pkg::NUM_LANES; i++) begin
        sums[i] <= '0;
      end
    end else if (cfg.win_clear) begin
      hv        <= '0;
      ring_slot <= '0;
      for (int i = 0; i < tpsa_pkg::NUM_LANES; i++) begin
        sums[i] <= '0;
      end
    end else begin
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_item;
            cnt <= '0;
            case (q_item.cmd)
              tpsa_pkg::CMD_SAMPLE: begin
                ring_slot <= slot_eff;
                at        <= at_next;
                at_ok     <= lane_ok;
                state     <= S_SWR;
              end
              tpsa_pkg::CMD_ADAPT: begin
                best    <= '0;
                busiest <= '0;
                state   <= S_LANE;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_SWR: begin
          if (at_ok) begin
            hv[at]        <= 1'b1;
            sums[sum_idx] <= sum_rd - SW'(old_cars) + SW'(cur.stopped_cars);
          end
          if (cur.snapshot_end) begin
            ring_slot <= (slot_inc >= cfg.wl) ? '0 : slot_inc[tpsa_pkg::SLOT_W-1:0];
          end
          state <= S_IDLE;
        end
        S_LANE: begin
          if ((cnt == '0) || (sum_rd > best)) begin
            best    <= sum_rd;
            busiest <= cnt[tpsa_pkg::LANE_W-1:0];
          end
          if (cnt == CW'(tpsa_pkg::NUM_LANES - 1)) begin
            cnt        <= '0;
            greens     <= '0;
            grow_found <= 1'b0;
            total      <= '0;
            state      <= S_PHASE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_PHASE: begin
          if (green) begin
            greens <= greens + 1'b1;
            if (lanes[pidx][busiest]) begin
              grow       <= pidx;
              grow_found <= 1'b1;
            end
          end
          total <= total + KW'(dur_rd);
          cnt   <= cnt + 1'b1;
          if (cnt == np_last) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          cnt   <= '0;
          start <= '0;
          prod  <= PRW'(dur_rd) * PRW'(cfg.gain);
          if (greens == '0) begin
            status <= tpsa_pkg::STAT_NO_GREEN;
            state  <= S_EMIT;
          end else if (!grow_found) begin
            status <= tpsa_pkg::STAT_UNSERVED;
            state  <= S_EMIT;
          end else begin
            status <= tpsa_pkg::STAT_ADAPTED;
            state  <= S_DIVS;
          end
        end
        S_DIVS: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            minus  <= div_q;
            others <= '0;
            state  <= S_UPD;
          end
        end
        S_UPD: begin
          if (pidx != grow) begin
            others <= others + KW'(dnew);
          end
          cnt <= cnt + 1'b1;
          if (cnt == np_last) begin
            state <= S_GROW;
          end
        end
        S_GROW: begin
          cnt   <= '0;
          start <= '0;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            res_phase  <= pidx;
            res_start  <= start;
            res_end    <= start + KW'(dur_rd) - 1'b1;
            res_status <= status;
            res_last   <= (cnt == np_last);
            start      <= start + KW'(dur_rd);
            cnt        <= cnt + 1'b1;
            if (cnt == np_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Phase table writes: loads, shrunk phases and the grown phase
  always_ff @(posedge clk) begin
    if (q_pop && (q_item.cmd == tpsa_pkg::CMD_LOAD) &&
        (int'(q_item.phase_index) < tpsa_pkg::MAX_PHASES)) begin
      dur[PW'(q_item.phase_index)]   <= (q_item.phase_time == '0) ? TW'(1)
                                                                  : q_item.phase_time;
      lanes[PW'(q_item.phase_index)] <= q_item.lane_mask;
    end else if ((state == S_UPD) && !cfg.win_clear && (pidx != grow) && green) begin
      dur[pidx] <= dnew;
    end else if ((state == S_GROW) && !cfg.win_clear) begin
      dur[grow] <= gnew;
    end
  end

  assign results.valid      = res_valid;
  assign results.out_phase  = tpsa_pkg::PIDX_W'(res_phase);
  assign results.start_tick = res_start;
  assign results.end_tick   = res_end;
  assign results.status     = res_status;
  assign results.last_phase = res_last;

  assign bstat.div_busy  = div_busy;
  assign bstat.in_div    = (state == S_DIV);
  assign bstat.out_load  = out_load;
  assign bstat.ring_zero = (ring_slot == '0);

endmodule

// ===== rtl/traffic_phase_split_adapter.sv =====
// Load writes the phase table from the queue; sample updates history; adapt scans lanes
// and phases, runs a 12-step divide and resizes phases if served, and emits results.
// One request at a time in the back end; the two-entry queue takes requests meanwhile.
// Results leave through an output register, one per cycle while the sink is ready.
// Reset (synchronous): registers to defaults, window sums, history and queue cleared;
// the phase table stays undefined until loaded.
`include "traffic_phase_split_adapter_defines.svh"

module traffic_phase_split_adapter (
  input  logic        clk,
  input  logic        rst,
  tpsa_in_if.sink     items,
  tpsa_out_if.source  results,
  tpsa_cfg_if.sink    cfg
);

  logic [tpsa_pkg::NP_W-1:0]   phase_count;
  logic [tpsa_pkg::WL_W-1:0]   window_length;
  logic [tpsa_pkg::TIME_W-1:0] min_phase_time;
  logic [tpsa_pkg::GAIN_W-1:0] gain_q8;
  logic                        win_clear;
  tpsa_pkg::cfg_t              cfg_bus;
  logic                        q_valid;
  tpsa_pkg::item_t             q_item;
  logic                        q_pop;
  tpsa_pkg::bstat_t            bstat;

  assign cfg.ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count    <= tpsa_pkg::RST_PHASE_COUNT;
      window_length  <= tpsa_pkg::RST_WINDOW_LENGTH;
      min_phase_time <= tpsa_pkg::RST_MIN_TIME;
      gain_q8        <= tpsa_pkg::RST_GAIN;
      win_clear      <= 1'b0;
    end else begin
      win_clear <= 1'b0;
      if (cfg.valid) begin
        case (cfg.addr)
          tpsa_pkg::REG_PHASE_COUNT:   phase_count <= cfg.data[tpsa_pkg::NP_W-1:0];
          tpsa_pkg::REG_WINDOW_LENGTH: begin
            window_length <= cfg.data[tpsa_pkg::WL_W-1:0];
            win_clear     <= 1'b1;
          end
          tpsa_pkg::REG_MIN_TIME:      min_phase_time <= cfg.data[tpsa_pkg::TIME_W-1:0];
          tpsa_pkg::REG_GAIN:          gain_q8 <= cfg.data[tpsa_pkg::GAIN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Clamp counts to their usable ranges
  always_comb begin
    if (phase_count == '0) begin
      cfg_bus.np = tpsa_pkg::NP_W'(1);
    end else if (int'(phase_count) > tpsa_pkg::MAX_PHASES) begin
      cfg_bus.np = tpsa_pkg::NP_W'(tpsa_pkg::MAX_PHASES);
    end else begin
      cfg_bus.np = phase_count;
    end
    if (window_length == '0) begin
      cfg_bus.wl = tpsa_pkg::WL_W'(1);
    end else if (int'(window_length) > tpsa_pkg::HISTORY_DEPTH) begin
      cfg_bus.wl = tpsa_pkg::WL_W'(tpsa_pkg::HISTORY_DEPTH);
    end else begin
      cfg_bus.wl = window_length;
    end
    cfg_bus.min_time  = min_phase_time;
    cfg_bus.gain      = gain_q8;
    cfg_bus.win_clear = win_clear;
  end

  tpsa_front u_front (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  tpsa_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_bus),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .results (results),
    .bstat   (bstat)
  );

  // Divider runs only while the sequencer waits on it
  `TPSA_ASSERT_NOW(a_div_owned, bstat.div_busy, bstat.in_div)
  // Never overwrite a result that the sink has not taken
  `TPSA_ASSERT_NOW(a_no_overwrite, bstat.out_load && results.valid, results.ready)
  // A window change restarts the ring at slot zero
  `TPSA_ASSERT_NEXT(a_win_restart, win_clear, bstat.ring_zero)

endmodule
